[design/assert_macros.svh]
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_SYNC(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error(msg);

`endif

[design/ipv6tp_pkg.sv]
// Shared types, constants and helpers for the IPv6 text address parser.
package ipv6tp_pkg;

    localparam int AddrWords   = 8;                        // 16-bit groups in an address
    localparam int WordW       = 16;
    localparam int AddrW       = AddrWords * WordW;
    localparam int PosW        = $clog2(AddrWords + 1);    // holds 0..AddrWords
    localparam int IdxW        = $clog2(AddrWords);
    localparam int GroupDigits = 4;
    localparam int DigitCntW   = $clog2(GroupDigits + 1);
    localparam int ColonCntW   = 2;                        // saturates, only <2 and ==2 matter

    localparam logic [7:0] CharColon  = 8'h3A;
    localparam logic [7:0] CharZero   = 8'h30;
    localparam logic [7:0] CharNine   = 8'h39;
    localparam logic [7:0] CharLowerA = 8'h61;
    localparam logic [7:0] CharLowerF = 8'h66;
    localparam logic [7:0] CharUpperA = 8'h41;
    localparam logic [7:0] CharUpperF = 8'h46;
    localparam logic [7:0] HexTen     = 8'd10;

    typedef enum logic [0:0] {
        ST_RUN,
        ST_PACK
    } ctrl_state_t;

    typedef struct packed {
        logic take;     // accept current character
        logic load;     // build result into output register, clear parse state
    } dp_cmd_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t r;
        r.ok    = 1'b1;
        r.value = 4'd0;
        if (c >= CharZero && c <= CharNine) begin
            r.value = 4'(c - CharZero);
        end else if (c >= CharLowerA && c <= CharLowerF) begin
            r.value = 4'(c - CharLowerA + HexTen);
        end else if (c >= CharUpperA && c <= CharUpperF) begin
            r.value = 4'(c - CharUpperA + HexTen);
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

[design/ipv6tp_ctrl.sv]
// Controller FSM: character intake, result build and output register handshake.
`include "assert_macros.svh"

module ipv6tp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tlast,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output ipv6tp_pkg::dp_cmd_t cmd
);

    ipv6tp_pkg::ctrl_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ipv6tp_pkg::ST_RUN;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd.take   = 1'b0;
        cmd.load   = 1'b0;
        out_free   = !out_valid_reg || m_tready;
        case (state_reg)
            ipv6tp_pkg::ST_RUN: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
                if (s_tvalid && s_tlast) begin
                    state_next = ipv6tp_pkg::ST_PACK;
                end
            end
            ipv6tp_pkg::ST_PACK: begin
                // wait for the output register to drain
                if (out_free) begin
                    cmd.load   = 1'b1;
                    state_next = ipv6tp_pkg::ST_RUN;
                end
            end
            default: begin
                state_next = ipv6tp_pkg::ST_RUN;
            end
        endcase

        if (cmd.load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

    `ASSERT_SYNC(a_last_stalls_intake, aclk, aresetn,
        (s_tvalid && s_tready && s_tlast) |=> !s_tready, "intake open after last char")
    `ASSERT_SYNC(a_load_sets_valid, aclk, aresetn,
        cmd.load |=> m_tvalid, "result load did not raise m_tvalid")
    `ASSERT_NEVER(a_take_load_excl, aclk, aresetn,
        cmd.take && cmd.load, "take and load in same cycle")

endmodule

[design/ipv6tp_datapath.sv]
// Datapath: group accumulator, word store, parse checks and gap expansion.
`include "assert_macros.svh"

module ipv6tp_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  ipv6tp_pkg::dp_cmd_t cmd,
    input  logic [7:0]          text_char,
    input  logic                final_char,
    output logic [63:0]         addr_upper,
    output logic [63:0]         addr_lower,
    output logic                parse_status
);

    localparam int PosW  = ipv6tp_pkg::PosW;
    localparam int IdxW  = ipv6tp_pkg::IdxW;
    localparam int WordW = ipv6tp_pkg::WordW;
    localparam int AddrW = ipv6tp_pkg::AddrW;
    localparam int CntW  = ipv6tp_pkg::DigitCntW;
    localparam int ColW  = ipv6tp_pkg::ColonCntW;

    localparam logic [PosW-1:0] PosFull   = PosW'(ipv6tp_pkg::AddrWords);
    localparam logic [CntW-1:0] CntFull   = CntW'(ipv6tp_pkg::GroupDigits);
    localparam logic [ColW-1:0] ColonMax  = '1;
    localparam logic [ColW-1:0] ColonTwo  = ColW'(2);

    // word store, no reset: only words below the fill position are read
    logic [WordW-1:0] word_reg [ipv6tp_pkg::AddrWords];

    logic [WordW-1:0] group_reg, group_next;
    logic [CntW-1:0]  cnt_reg,   cnt_next;
    logic [PosW-1:0]  pos_reg,   pos_next;     // next word to fill
    logic [PosW-1:0]  gap_reg,   gap_next;     // word position of double colon
    logic [ColW-1:0]  colon_reg, colon_next;
    logic             error_reg, error_next;

    logic [63:0] upper_reg, lower_reg;
    logic        status_reg;

    ipv6tp_pkg::hex_t  dec;
    logic              is_colon;
    logic              digit_err;
    logic [WordW-1:0]  group_step;
    logic [CntW-1:0]   digits;
    logic [ColW-1:0]   colon_step;
    logic              word_we;

    // expansion
    logic [PosW-1:0]   gap_eff;
    logic [PosW-1:0]   zero_words;
    logic [PosW:0]     tail_start;
    logic [AddrW-1:0]  flat;
    logic [AddrW-1:0]  shifted;
    logic [AddrW-1:0]  expanded;
    logic              final_err;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_reg <= '0;
            cnt_reg   <= '0;
            pos_reg   <= '0;
            gap_reg   <= '0;
            colon_reg <= '0;
            error_reg <= 1'b0;
        end else begin
            group_reg <= group_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
            gap_reg   <= gap_next;
            colon_reg <= colon_next;
            error_reg <= error_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (word_we) begin
            word_reg[pos_reg[IdxW-1:0]] <= group_step;
        end
        if (cmd.load) begin
            upper_reg  <= final_err ? 64'd0 : expanded[AddrW-1 -: 64];
            lower_reg  <= final_err ? 64'd0 : expanded[63:0];
            status_reg <= final_err;
        end
    end

    // character intake
    always_comb begin
        dec        = ipv6tp_pkg::hex_decode(text_char);
        is_colon   = (text_char == ipv6tp_pkg::CharColon);
        digit_err  = 1'b0;
        group_step = group_reg;
        digits     = cnt_reg;
        colon_step = colon_reg;
        word_we    = 1'b0;

        group_next = group_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        gap_next   = gap_reg;
        colon_next = colon_reg;
        error_next = error_reg;

        if (cmd.take && !error_reg) begin
            if (!dec.ok && !is_colon && !final_char) begin
                error_next = 1'b1;                  // stray character
            end else begin
                if (dec.ok) begin
                    // store full or fifth digit in a group is a digit error
                    if (pos_reg == PosFull || cnt_reg == CntFull) begin
                        digit_err = 1'b1;
                    end else begin
                        group_step = {group_reg[WordW-5:0], dec.value};
                        digits     = cnt_reg + 1'b1;
                    end
                end
                if (digit_err) begin
                    error_next = 1'b1;
                end else if (is_colon || final_char) begin
                    if (is_colon && colon_reg != ColonMax) begin
                        colon_step = colon_reg + 1'b1;
                    end
                    colon_next = colon_step;
                    group_next = '0;
                    cnt_next   = '0;
                    if (digits != '0) begin
                        // group is left padded by construction
                        word_we  = 1'b1;
                        pos_next = pos_reg + 1'b1;
                    end else if (gap_reg != '0 && colon_step != ColonTwo) begin
                        error_next = 1'b1;          // second double colon
                    end else begin
                        gap_next = pos_reg;
                    end
                end else begin
                    group_next = group_step;
                    cnt_next   = digits;
                end
            end
        end

        if (cmd.load) begin
            group_next = '0;
            cnt_next   = '0;
            pos_next   = '0;
            gap_next   = '0;
            colon_next = '0;
            error_next = 1'b0;
        end
    end

    // gap expansion: head words stay, zeros fill, tail moves to the end
    always_comb begin
        final_err  = error_reg || (colon_reg < ColonTwo);
        gap_eff    = (gap_reg > pos_reg) ? pos_reg : gap_reg;
        zero_words = PosFull - pos_reg;
        tail_start = {1'b0, gap_eff} + {1'b0, zero_words};
        for (int k = 0; k < ipv6tp_pkg::AddrWords; k++) begin
            flat[AddrW-1-k*WordW -: WordW] = word_reg[k];
        end
        shifted = flat >> {zero_words, 4'd0};
        for (int k = 0; k < ipv6tp_pkg::AddrWords; k++) begin
            if ((PosW+1)'(k) < {1'b0, gap_eff}) begin
                expanded[AddrW-1-k*WordW -: WordW] = flat[AddrW-1-k*WordW -: WordW];
            end else if ((PosW+1)'(k) < tail_start) begin
                expanded[AddrW-1-k*WordW -: WordW] = '0;
            end else begin
                expanded[AddrW-1-k*WordW -: WordW] = shifted[AddrW-1-k*WordW -: WordW];
            end
        end
    end

    assign addr_upper   = upper_reg;
    assign addr_lower   = lower_reg;
    assign parse_status = status_reg;

    `ASSERT_SYNC(a_gap_within_fill, aclk, aresetn,
        gap_reg <= pos_reg, "double colon recorded past fill position")
    `ASSERT_SYNC(a_load_clears, aclk, aresetn,
        cmd.load |=> (pos_reg == '0 && !error_reg && colon_reg == '0),
        "parse state not cleared after result")

endmodule

[design/ipv6_text_address_parser.sv]
// Top level of the IPv6 text address parser: controller plus datapath.
// Throughput: one character per cycle while ST_RUN holds intake open; the last
//   character of a string closes intake for the result build pass in ST_PACK, longer while m_tvalid waits.
// Result: the load in ST_PACK sets the registered m_tvalid flag.
// Reset: aresetn is synchronous, active low; it clears parse state and the
//   output valid flag. The group store and result payload are not reset.
module ipv6_text_address_parser (
    input  logic         aclk,
    input  logic         aresetn,
    // character stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,     // [7:0] text_char
    input  logic         s_tlast,     // final_char
    // address results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,     // [63:0] addr_upper, [127:64] addr_lower
    output logic         m_tuser      // [0] parse_status (1 = invalid, address zero)
);

    // Command bundle from the FSM to the datapath:
    //   take - a character transfer happens this cycle
    //   load - build the expanded address into the output register and clear
    ipv6tp_pkg::dp_cmd_t cmd;

    logic [63:0] addr_upper;
    logic [63:0] addr_lower;
    logic        parse_status;

    // FSM: ST_RUN takes characters; the last one moves it to ST_PACK, which
    // loads the output register as soon as that register is free or drains.
    ipv6tp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Datapath: hex digits shift into a 16-bit group register which lands in
    // an eight-word store when the group closes (colon or last character).
    // A double colon records its word position; the result pass moves the
    // tail words to the end through one word-granular barrel shift.
    ipv6tp_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .text_char    (s_tdata),
        .final_char   (s_tlast),
        .addr_upper   (addr_upper),
        .addr_lower   (addr_lower),
        .parse_status (parse_status)
    );

    assign m_tdata = {addr_lower, addr_upper};
    assign m_tuser = parse_status;

endmodule
